// File: rtl/tcps_pkg.sv
// Shared types and constants for the trie common prefix search block.
package tcps_pkg;

    localparam int KEY_W      = 21;
    localparam int VAL_W      = 32;
    localparam int PTR_W      = 16;
    localparam int LEN_W      = 9;
    localparam int MAXLEN_W   = 8;
    localparam int KV_W       = KEY_W + VAL_W;
    localparam int CH_W       = 2 * PTR_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = 8'd255;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic             kind;
        logic [PTR_W-1:0] node_address;
        logic [KEY_W-1:0] node_key;
        logic [VAL_W-1:0] node_payload;
        logic [PTR_W-1:0] child_offset;
        logic [PTR_W-1:0] child_count;
        logic [KEY_W-1:0] text_char;
        logic             text_last;
        logic             addr_ok;
        logic             char_zero;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHILD,
        ST_KEY
    } back_state_t;

endpackage

// File: rtl/trie_common_prefix_search.sv
// Top level of the trie common prefix search block.
//
// Load items write one trie node from the idle state of the back end. A text
// character that finds the walk dead or stops before any lookup is settled
// in the idle state alone; otherwise the back end reads the child store,
// then the key store once for each child scanned in index order until a key
// matches or the children run out, one child at a time through the key
// store's single read port. A four-entry queue lets the front keep taking
// transfers while the back end walks or the result register waits.
module trie_common_prefix_search
    import tcps_pkg::*;
#(
    parameter int NODE_COUNT = 65536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_enable,
    input  logic [MAXLEN_W-1:0] cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [PTR_W-1:0]    node_address,
    input  logic [KEY_W-1:0]    node_key,
    input  logic [VAL_W-1:0]    node_payload,
    input  logic [PTR_W-1:0]    child_offset,
    input  logic [PTR_W-1:0]    child_count,
    input  logic [KEY_W-1:0]    text_char,
    input  logic                text_last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                matched,
    output logic [LEN_W-1:0]    match_length,
    output logic [VAL_W-1:0]    match_value,
    output logic                walk_ended
);

    logic [MAXLEN_W-1:0] max_length_reg;
    logic                queue_full, push, pop, head_valid;
    item_t               push_item, head;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write_enable)
        begin
            max_length_reg <= cfg_write_data;
        end
    end

    tcps_front #(.NODE_COUNT(NODE_COUNT)) u_front
    (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .node_address (node_address),
        .node_key     (node_key),
        .node_payload (node_payload),
        .child_offset (child_offset),
        .child_count  (child_count),
        .text_char    (text_char),
        .text_last    (text_last),
        .queue_full   (queue_full),
        .push         (push),
        .item         (push_item)
    );

    tcps_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tcps_back #(.NODE_COUNT(NODE_COUNT)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .max_length   (max_length_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched),
        .match_length (match_length),
        .match_value  (match_value),
        .walk_ended   (walk_ended)
    );

endmodule

// File: rtl/tcps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcps_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tcps_front.sv
// Front end: accepts input transfers and classifies them for the back end.
module tcps_front
    import tcps_pkg::*;
#(
    parameter int NODE_COUNT = 65536
)
(
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [PTR_W-1:0] node_address,
    input  logic [KEY_W-1:0] node_key,
    input  logic [VAL_W-1:0] node_payload,
    input  logic [PTR_W-1:0] child_offset,
    input  logic [PTR_W-1:0] child_count,
    input  logic [KEY_W-1:0] text_char,
    input  logic             text_last,
    input  logic             queue_full,
    output logic             push,
    output item_t            item
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int EW = ((AW > PTR_W) ? AW : PTR_W) + 1;
    localparam logic [EW-1:0] NC_E = EW'(NODE_COUNT);

    // hold the input while the queue has no room
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // classify: address range for loads, end of text for characters
    always_comb
    begin
        item.kind         = kind;
        item.node_address = node_address;
        item.node_key     = node_key;
        item.node_payload = node_payload;
        item.child_offset = child_offset;
        item.child_count  = child_count;
        item.text_char    = text_char;
        item.text_last    = text_last;
        item.addr_ok      = EW'(node_address) < NC_E;
        item.char_zero    = (text_char == '0);
    end

endmodule

// File: rtl/tcps_queue.sv
// Short register queue between the front and back ends.
module tcps_queue
    import tcps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head
);

    item_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/tcps_back.sv
// Back end: node memories, trie walk sequencer and result register.
module tcps_back
    import tcps_pkg::*;
#(
    parameter int NODE_COUNT = 65536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  item_t               head,
    output logic                pop,
    input  logic [MAXLEN_W-1:0] max_length,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                matched,
    output logic [LEN_W-1:0]    match_length,
    output logic [VAL_W-1:0]    match_value,
    output logic                walk_ended
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int IW = ((AW > PTR_W) ? AW : PTR_W) + 2;
    localparam logic [IW-1:0] NC_I = IW'(NODE_COUNT);

    back_state_t        state_reg, state_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               alive_reg, alive_next;
    logic [KEY_W-1:0]   char_reg, char_next;
    logic               last_reg, last_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [PTR_W-1:0]   remain_reg, remain_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_matched_reg, out_matched_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic [VAL_W-1:0]   out_val_reg, out_val_next;
    logic               out_ended_reg, out_ended_next;

    logic               kv_we, ch_we, kv_re, ch_re;
    logic [AW-1:0]      waddr, raddr;
    logic [KV_W-1:0]    kv_rdata;
    logic [CH_W-1:0]    ch_rdata;

    logic               out_free;
    logic               emit, em_match, em_end, restart;
    logic [LEN_W-1:0]   em_len;
    logic [VAL_W-1:0]   em_val;
    logic [PTR_W-1:0]   ch_off, ch_cnt;
    logic [KEY_W-1:0]   kv_key;
    logic [VAL_W-1:0]   kv_val;
    logic [IW-1:0]      base, nidx;
    logic [LEN_W-1:0]   len_inc;

    // node key and value store: key in the low bits, value above
    tcps_ram #(.WIDTH(KV_W), .DEPTH(NODE_COUNT)) u_kv_ram
    (
        .clk   (clk),
        .we    (kv_we),
        .waddr (waddr),
        .wdata ({head.node_payload, head.node_key}),
        .re    (kv_re),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    // node child store: offset in the low half, count above
    tcps_ram #(.WIDTH(CH_W), .DEPTH(NODE_COUNT)) u_ch_ram
    (
        .clk   (clk),
        .we    (ch_we),
        .waddr (waddr),
        .wdata ({head.child_count, head.child_offset}),
        .re    (ch_re),
        .raddr (raddr),
        .rdata (ch_rdata)
    );

    assign waddr   = IW'(head.node_address) > '0 ? AW'(IW'(head.node_address)) : '0;
    assign ch_off  = ch_rdata[PTR_W-1:0];
    assign ch_cnt  = ch_rdata[CH_W-1:PTR_W];
    assign kv_key  = kv_rdata[KEY_W-1:0];
    assign kv_val  = kv_rdata[KV_W-1:KEY_W];
    assign base    = IW'(cur_reg) + IW'(ch_off);
    assign nidx    = idx_reg + 1'b1;
    assign len_inc = len_reg + 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    // sequence the walk: at most one memory read per cycle
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        len_next    = len_reg;
        alive_next  = alive_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        remain_next = remain_reg;
        pop         = 1'b0;
        kv_we       = 1'b0;
        ch_we       = 1'b0;
        kv_re       = 1'b0;
        ch_re       = 1'b0;
        raddr       = cur_reg;
        emit        = 1'b0;
        em_match    = 1'b0;
        em_len      = '0;
        em_val      = '0;
        em_end      = 1'b0;
        restart     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && (head.kind == KIND_LOAD || out_free))
                begin
                    pop = 1'b1;
                    if (head.kind == KIND_LOAD)
                    begin
                        kv_we = head.addr_ok;
                        ch_we = head.addr_ok;
                    end
                    else
                    begin
                        char_next = head.text_char;
                        last_next = head.text_last;
                        if (!alive_reg)
                        begin
                            // dead walk: report only the end of text
                            if (head.char_zero || head.text_last)
                            begin
                                emit    = 1'b1;
                                em_end  = 1'b1;
                                restart = 1'b1;
                            end
                        end
                        else if (head.char_zero || len_reg > {1'b0, max_length})
                        begin
                            emit       = 1'b1;
                            em_end     = 1'b1;
                            alive_next = 1'b0;
                            restart    = head.char_zero || head.text_last;
                        end
                        else
                        begin
                            ch_re      = 1'b1;
                            raddr      = cur_reg;
                            state_next = ST_CHILD;
                        end
                    end
                end
            end

            ST_CHILD:
            begin
                if (ch_off == '0 || ch_cnt == '0 || base >= NC_I)
                begin
                    emit       = 1'b1;
                    em_end     = 1'b1;
                    alive_next = 1'b0;
                    restart    = last_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    kv_re       = 1'b1;
                    raddr       = base[AW-1:0];
                    idx_next    = base;
                    remain_next = ch_cnt;
                    state_next  = ST_KEY;
                end
            end

            ST_KEY:
            begin
                if (kv_key == char_reg)
                begin
                    // hit: step to the child
                    len_next   = len_inc;
                    cur_next   = idx_reg[AW-1:0];
                    em_match   = (kv_val != '0);
                    em_len     = em_match ? len_inc : '0;
                    em_val     = em_match ? kv_val : '0;
                    em_end     = last_reg;
                    emit       = em_match || last_reg;
                    restart    = last_reg;
                    state_next = ST_IDLE;
                end
                else if (remain_reg == PTR_W'(1) || nidx >= NC_I)
                begin
                    emit       = 1'b1;
                    em_end     = 1'b1;
                    alive_next = 1'b0;
                    restart    = last_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    kv_re       = 1'b1;
                    raddr       = nidx[AW-1:0];
                    idx_next    = nidx;
                    remain_next = remain_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // restart at the root after the end of a text
        if (restart)
        begin
            cur_next   = '0;
            len_next   = '0;
            alive_next = 1'b1;
        end

        // load or drain the result register
        out_valid_next   = out_valid_reg && out_stall;
        out_matched_next = out_matched_reg;
        out_len_next     = out_len_reg;
        out_val_next     = out_val_reg;
        out_ended_next   = out_ended_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_matched_next = em_match;
            out_len_next     = em_len;
            out_val_next     = em_val;
            out_ended_next   = em_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            len_reg       <= '0;
            alive_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            len_reg       <= len_next;
            alive_reg     <= alive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        char_reg        <= char_next;
        last_reg        <= last_next;
        idx_reg         <= idx_next;
        remain_reg      <= remain_next;
        out_matched_reg <= out_matched_next;
        out_len_reg     <= out_len_next;
        out_val_reg     <= out_val_next;
        out_ended_reg   <= out_ended_next;
    end

    assign out_valid    = out_valid_reg;
    assign matched      = out_matched_reg;
    assign match_length = out_len_reg;
    assign match_value  = out_val_reg;
    assign walk_ended   = out_ended_reg;

endmodule

// File: rtl/tcps_checker.sv
// Port-level checker for the trie common prefix search block, with its bind.
module tcps_checker
    import tcps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic                matched,
    input logic [LEN_W-1:0]    match_length,
    input logic [VAL_W-1:0]    match_value,
    input logic                walk_ended
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_length)
            && $stable(match_value) && $stable(matched) && $stable(walk_ended))
        else $error("stalled result changed");

    // a result without a match carries zero length and value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> match_length == '0 && match_value == '0)
        else $error("unmatched result has nonzero fields");

    // a match has a length between one and the walk bound
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> match_length != '0 && match_length <= 9'd256
            && match_value != '0)
        else $error("match fields out of range");

    // every result reports a match or the end of the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> matched || walk_ended)
        else $error("empty result transfer");

endmodule

bind trie_common_prefix_search tcps_checker u_tcps_checker (.*);
